// ----- src/hrhp_pkg.sv -----
// Shared types and constants for the HTTP request head parser.
`default_nettype none
package hrhp_pkg;

   localparam int OffW = 13;

   typedef enum logic [4:0] {
      S_LINE_START, S_METHOD, S_SP_URI, S_URI, S_SP_HTTP, S_H, S_HT, S_HTT,
      S_HTTP, S_SLASH, S_MAJOR, S_DOT, S_MINOR, S_SP_AFTER, S_LINE_CR,
      S_HDR_START, S_KEY, S_KEY_END, S_COLON, S_VALUE, S_CR, S_CRLF, S_CRLFCR
   } parse_state_type;

   typedef enum logic [2:0] {
      ST_BUSY, ST_LINE, ST_HEADER, ST_HEAD, E_METHOD, E_URI, E_VERSION, E_LINE
   } status_type;

   localparam logic [1:0] M_UNKNOWN = 2'd0;
   localparam logic [1:0] M_GET     = 2'd1;
   localparam logic [1:0] M_POST    = 2'd2;
   localparam logic [1:0] M_HEAD    = 2'd3;

   localparam logic [31:0] WORD_GET  = 32'h0047_4554;
   localparam logic [31:0] WORD_POST = 32'h504F_5354;
   localparam logic [31:0] WORD_HEAD = 32'h4845_4144;

   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SP    = 8'd32;
   localparam logic [7:0] CH_SLASH = 8'd47;
   localparam logic [7:0] CH_DOT   = 8'd46;
   localparam logic [7:0] CH_COLON = 8'd58;
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_H     = 8'd72;
   localparam logic [7:0] CH_T     = 8'd84;
   localparam logic [7:0] CH_P     = 8'd80;

   // one queued byte between front and back
   typedef struct packed {
      logic [7:0] data_byte;
      logic       restart;
      logic       is_digit;
      logic       is_upper;
   } item_type;

   // decimal accumulate with saturation at 255
   function automatic logic [7:0] dec_acc(input logic [7:0] v, input logic [7:0] c);
      logic [11:0] n;
      n = {v, 3'b000} + {3'b000, v, 1'b0} + {8'd0, c[3:0]};
      return (n > 12'd255) ? 8'd255 : n[7:0];
   endfunction

endpackage
`default_nettype wire

// ----- src/hrhp_front.sv -----
// Front stage: accept bytes, classify them and queue them for the parser.
`default_nettype none
module hrhp_front
   import hrhp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_restart,
   output logic            q_valid,
   input  wire logic       q_ready,
   output item_type        q_item
);
   // two-entry queue
   item_type   slot_ff [2];
   logic       rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;
   item_type   cls;

   // classify the incoming byte
   always_comb begin
      cls.data_byte = req_data_byte;
      cls.restart   = req_restart;
      cls.is_digit  = (req_data_byte >= 8'd48) && (req_data_byte <= 8'd57);
      cls.is_upper  = (req_data_byte >= 8'd65) && (req_data_byte <= 8'd90);
   end

   assign req_ready = (count_ff != 2'd2);
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   always_comb begin
      rd_ptr_in = rd_ptr_ff ^ pop;
      wr_ptr_in = wr_ptr_ff ^ push;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   // advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the transaction
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cls;
      end
   end

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2) |-> !push) else $error("push into full queue");
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 2'd1))
      else $error("pop did not drop count");
endmodule
`default_nettype wire

// ----- src/hrhp_back.sv -----
// Back stage: one state machine for the request line and headers, with an output register.
`default_nettype none
module hrhp_back
   import hrhp_pkg::*;
#(
   parameter int BUFFER_SIZE = 8192
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       q_valid,
   output logic            q_ready,
   input  item_type        q_item,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [2:0]      rsp_status,
   output logic [1:0]      rsp_method,
   output logic [OffW-1:0] rsp_uri_begin,
   output logic [OffW-1:0] rsp_uri_finish,
   output logic [7:0]      rsp_version_major,
   output logic [7:0]      rsp_version_minor,
   output logic [OffW-1:0] rsp_key_begin,
   output logic [OffW-1:0] rsp_key_finish,
   output logic [OffW-1:0] rsp_value_begin,
   output logic [OffW-1:0] rsp_value_finish
);
   localparam int PW = $clog2(BUFFER_SIZE + 1);

   parse_state_type state_ff, state_in, s0;
   logic [PW-1:0]   off_ff, off_in, p, p1;
   logic [31:0]     let_ff, let_in, l0;
   logic [2:0]      len_ff, len_in, n0;
   logic [1:0]      meth_ff, meth_in, m0;
   logic [OffW-1:0] ub_ff, ub_in, ue_ff, ue_in, kb_ff, kb_in, ke_ff, ke_in;
   logic [OffW-1:0] vb_ff, vb_in, ve_ff, ve_in, pl;
   logic [OffW-1:0] ub0, ue0, kb0, ke0, vb0, ve0;
   logic [7:0]      maj_ff, maj_in, min_ff, min_in, mj0, mn0;
   status_type      err_ff, err_in, e0, st;
   logic [7:0]      c;
   logic            step, outv_ff;

   assign q_ready = !outv_ff || rsp_ready;
   assign step    = q_valid && q_ready;
   assign c       = q_item.data_byte;

   always_comb begin
      // apply restart before the byte
      s0  = q_item.restart ? S_LINE_START : state_ff;
      p   = q_item.restart ? '0 : off_ff;
      l0  = q_item.restart ? '0 : let_ff;
      n0  = q_item.restart ? '0 : len_ff;
      m0  = q_item.restart ? M_UNKNOWN : meth_ff;
      ub0 = q_item.restart ? '0 : ub_ff;
      ue0 = q_item.restart ? '0 : ue_ff;
      kb0 = q_item.restart ? '0 : kb_ff;
      ke0 = q_item.restart ? '0 : ke_ff;
      vb0 = q_item.restart ? '0 : vb_ff;
      ve0 = q_item.restart ? '0 : ve_ff;
      mj0 = q_item.restart ? '0 : maj_ff;
      mn0 = q_item.restart ? '0 : min_ff;
      e0  = q_item.restart ? ST_BUSY : err_ff;
      pl  = p[OffW-1:0];
      p1  = p + PW'(1);

      state_in = s0; let_in = l0; len_in = n0; meth_in = m0;
      ub_in = ub0; ue_in = ue0; kb_in = kb0; ke_in = ke0; vb_in = vb0; ve_in = ve0;
      maj_in = mj0; min_in = mn0; err_in = e0; st = ST_BUSY;
      off_in = (p1 >= PW'(BUFFER_SIZE)) ? '0 : p1;

      if (e0 != ST_BUSY) begin
         st = e0;
      end else begin
         case (s0)
            S_LINE_START: begin
               if (c == CH_CR || c == CH_LF || c == CH_SP) st = ST_BUSY;
               else if (!q_item.is_upper) st = E_METHOD;
               else begin
                  let_in = {24'd0, c}; len_in = 3'd1; state_in = S_METHOD;
               end
            end
            S_METHOD: begin
               if (c == CH_SP) begin
                  if (n0 == 3'd3 && l0 == WORD_GET) meth_in = M_GET;
                  else if (n0 == 3'd4 && l0 == WORD_POST) meth_in = M_POST;
                  else if (n0 == 3'd4 && l0 == WORD_HEAD) meth_in = M_HEAD;
                  else meth_in = M_UNKNOWN;
                  state_in = S_SP_URI;
               end else if (!q_item.is_upper) st = E_METHOD;
               else begin
                  if (n0 < 3'd4) let_in = {l0[23:0], c};
                  if (n0 < 3'd7) len_in = n0 + 3'd1;
               end
            end
            S_SP_URI: begin
               if (c == CH_SLASH) begin ub_in = pl; state_in = S_URI; end
               else if (c != CH_SP) st = E_URI;
            end
            S_URI: begin
               if (c == CH_SP) begin ue_in = pl; state_in = S_SP_HTTP; end
            end
            S_SP_HTTP: begin
               if (c == CH_H) state_in = S_H;
               else if (c != CH_SP) st = E_VERSION;
            end
            S_H:    if (c == CH_T) state_in = S_HT; else st = E_VERSION;
            S_HT:   if (c == CH_T) state_in = S_HTT; else st = E_VERSION;
            S_HTT:  if (c == CH_P) state_in = S_HTTP; else st = E_VERSION;
            S_HTTP: if (c == CH_SLASH) state_in = S_SLASH; else st = E_VERSION;
            S_SLASH: begin
               if (!q_item.is_digit) st = E_VERSION;
               else begin maj_in = c - CH_ZERO; state_in = S_MAJOR; end
            end
            S_MAJOR: begin
               if (c == CH_DOT) state_in = S_DOT;
               else if (!q_item.is_digit) st = E_VERSION;
               else maj_in = dec_acc(mj0, c);
            end
            S_DOT: begin
               if (!q_item.is_digit) st = E_VERSION;
               else begin min_in = c - CH_ZERO; state_in = S_MINOR; end
            end
            S_MINOR: begin
               if (c == CH_CR) state_in = S_LINE_CR;
               else if (c == CH_SP) state_in = S_SP_AFTER;
               else if (c == CH_LF) begin st = ST_LINE; state_in = S_HDR_START; end
               else if (!q_item.is_digit) st = E_VERSION;
               else min_in = dec_acc(mn0, c);
            end
            S_SP_AFTER: begin
               if (c == CH_SP) st = ST_BUSY;
               else if (c == CH_CR) state_in = S_LINE_CR;
               else if (c == CH_LF) begin st = ST_LINE; state_in = S_HDR_START; end
               else st = E_LINE;
            end
            S_LINE_CR: begin
               if (c == CH_LF) begin st = ST_LINE; state_in = S_HDR_START; end
               else st = E_LINE;
            end
            S_HDR_START: begin
               if (c == CH_CR || c == CH_LF) begin st = ST_HEAD; state_in = S_LINE_START; end
               else begin kb_in = pl; state_in = S_KEY; end
            end
            S_KEY: begin
               if (c == CH_SP) begin ke_in = pl; state_in = S_KEY_END; end
               else if (c == CH_COLON) begin ke_in = pl; state_in = S_COLON; end
            end
            S_KEY_END: begin
               if (c == CH_COLON) state_in = S_COLON;
               else if (c != CH_SP) st = E_LINE;
            end
            S_COLON: begin
               if (c != CH_SP) begin vb_in = pl; state_in = S_VALUE; end
            end
            S_VALUE: begin
               if (c == CH_CR) begin ve_in = pl; state_in = S_CR; end
               else if (c == CH_LF) begin ve_in = pl; state_in = S_CRLF; end
            end
            S_CR: begin
               if (c == CH_LF) begin st = ST_HEADER; state_in = S_CRLF; end
               else st = E_LINE;
            end
            S_CRLF: begin
               if (c == CH_CR) state_in = S_CRLFCR;
               else begin kb_in = pl; state_in = S_KEY; end
            end
            S_CRLFCR: begin
               if (c == CH_LF) begin st = ST_HEAD; state_in = S_LINE_START; end
               else st = E_LINE;
            end
            default: state_in = S_LINE_START;
         endcase
         if (st >= E_METHOD) err_in = st;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LINE_START; off_ff <= '0; err_ff <= ST_BUSY; outv_ff <= 1'b0;
         let_ff <= '0; len_ff <= '0; meth_ff <= M_UNKNOWN;
         ub_ff <= '0; ue_ff <= '0; kb_ff <= '0; ke_ff <= '0; vb_ff <= '0; ve_ff <= '0;
         maj_ff <= '0; min_ff <= '0;
      end else begin
         if (step) begin
            state_ff <= state_in; off_ff <= off_in; err_ff <= err_in;
            let_ff <= let_in; len_ff <= len_in; meth_ff <= meth_in;
            ub_ff <= ub_in; ue_ff <= ue_in; kb_ff <= kb_in; ke_ff <= ke_in;
            vb_ff <= vb_in; ve_ff <= ve_in; maj_ff <= maj_in; min_ff <= min_in;
         end
         if (step) outv_ff <= 1'b1;
         else if (rsp_ready) outv_ff <= 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_status <= st; rsp_method <= meth_in;
         rsp_uri_begin <= ub_in; rsp_uri_finish <= ue_in;
         rsp_version_major <= maj_in; rsp_version_minor <= min_in;
         rsp_key_begin <= kb_in; rsp_key_finish <= ke_in;
         rsp_value_begin <= vb_in; rsp_value_finish <= ve_in;
      end
   end

   assign rsp_valid = outv_ff;

   a_off_range: assert property (@(posedge clock) disable iff (reset)
      off_ff < PW'(BUFFER_SIZE)) else $error("offset beyond buffer");
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (step && !q_item.restart && err_ff != ST_BUSY) |=> (err_ff == $past(err_ff)))
      else $error("error not sticky");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (outv_ff && !rsp_ready) |-> !step) else $error("overwrote pending result");
endmodule
`default_nettype wire

// ----- src/http_request_head_parser_core.sv -----
// Top level of the HTTP request head parser.
//  channel | ports                  | direction | transfers
//  req     | req_valid/req_ready    | in        | one byte and restart flag
//  rsp     | rsp_valid/rsp_ready    | out       | one status per byte
// One byte per clock sustained while rsp_ready stays high; each byte passes the queue, then the parser register.
// The parse state loop in the back stage sets the one-byte-per-cycle figure.
// Synchronous reset returns the parser to line start at offset zero.
// A stalled rsp side fills the two-entry queue, then drops req_ready.
`default_nettype none
module http_request_head_parser_core
   import hrhp_pkg::*;
#(
   parameter int BUFFER_SIZE = 8192
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_restart,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [2:0]      rsp_status,
   output logic [1:0]      rsp_method,
   output logic [12:0]     rsp_uri_begin,
   output logic [12:0]     rsp_uri_finish,
   output logic [7:0]      rsp_version_major,
   output logic [7:0]      rsp_version_minor,
   output logic [12:0]     rsp_key_begin,
   output logic [12:0]     rsp_key_finish,
   output logic [12:0]     rsp_value_begin,
   output logic [12:0]     rsp_value_finish
);
   logic     q_valid, q_ready;
   item_type q_item;

   hrhp_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data_byte, .req_restart,
      .q_valid, .q_ready, .q_item
   );

   hrhp_back #(.BUFFER_SIZE(BUFFER_SIZE)) u_back (
      .clock, .reset, .q_valid, .q_ready, .q_item,
      .rsp_valid, .rsp_ready, .rsp_status, .rsp_method,
      .rsp_uri_begin, .rsp_uri_finish, .rsp_version_major, .rsp_version_minor,
      .rsp_key_begin, .rsp_key_finish, .rsp_value_begin, .rsp_value_finish
   );
endmodule
`default_nettype wire
